/* rtl/rkt_pkg.sv */
package rkt_pkg;

    // Table geometry
    localparam int SLOTS      = 64;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int TOP_BITS   = $clog2(SLOTS + 1);
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 64;
    localparam int STS_BITS   = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Request opcodes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Response status codes
    localparam logic [STS_BITS-1:0] ST_OK     = 2'd0;
    localparam logic [STS_BITS-1:0] ST_FULL   = 2'd1;
    localparam logic [STS_BITS-1:0] ST_ABSENT = 2'd2;

    // Free stack control from the sequencer
    typedef struct packed {
        logic                 rd;
        logic                 pop;
        logic                 push;
        logic [SLOT_BITS-1:0] push_slot;
    } t_stk_ctl;

    // Free stack status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_sts;

    // One pending response
    typedef struct packed {
        logic [STS_BITS-1:0]   status;
        logic [SLOT_BITS-1:0]  slot_out;
        logic [COUNT_BITS-1:0] ref_total;
        logic                  released;
    } t_rsp;

endpackage

/* rtl/rkt_if.sv */
interface rkt_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [rkt_pkg::KEY_BITS-1:0]  key;
    logic [rkt_pkg::COUNT_BITS-1:0] ref_delta;
    logic [rkt_pkg::SLOT_BITS-1:0] slot_in;

    modport source (output valid, op, key, ref_delta, slot_in, input ready);
    modport sink   (input valid, op, key, ref_delta, slot_in, output ready);
endinterface

interface rkt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rkt_pkg::STS_BITS-1:0]   status;
    logic [rkt_pkg::SLOT_BITS-1:0]  slot_out;
    logic [rkt_pkg::COUNT_BITS-1:0] ref_total;
    logic                           released;

    modport source (output valid, status, slot_out, ref_total, released, input ready);
    modport sink   (input valid, status, slot_out, ref_total, released, output ready);
endinterface

/* rtl/rkt_free_stack.sv */
module rkt_free_stack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rkt_pkg::t_stk_ctl             i_ctl,
    output rkt_pkg::t_stk_sts             o_sts,
    output logic [rkt_pkg::SLOT_BITS-1:0] o_slot
);

    // LIFO of free slot numbers; top entry sits at index SLOTS - r_top
    logic [rkt_pkg::SLOT_BITS-1:0] m_stack [rkt_pkg::SLOTS];
    logic [rkt_pkg::SLOTS-1:0]     r_ent_vld;
    logic [rkt_pkg::TOP_BITS-1:0]  r_top;
    logic [rkt_pkg::TOP_BITS-1:0]  n_top;
    logic [rkt_pkg::SLOT_BITS-1:0] r_rd_data;
    logic [rkt_pkg::SLOT_BITS-1:0] r_rd_addr;
    logic                          r_rd_vld;
    logic [rkt_pkg::TOP_BITS-1:0]  rd_ptr;
    logic [rkt_pkg::TOP_BITS-1:0]  wr_ptr;

    assign rd_ptr = rkt_pkg::TOP_BITS'(rkt_pkg::SLOTS) - r_top;
    assign wr_ptr = rkt_pkg::TOP_BITS'(rkt_pkg::SLOTS - 1) - r_top;

    assign o_sts.empty = (r_top == '0);
    assign o_sts.full  = (r_top == rkt_pkg::TOP_BITS'(rkt_pkg::SLOTS));

    // An entry never written holds its own index
    assign o_slot = r_rd_vld ? r_rd_data : r_rd_addr;

    // Top pointer
    always_comb begin
        n_top = r_top;
        if (i_ctl.pop) begin
            n_top = r_top - rkt_pkg::TOP_BITS'(1);
        end else if (i_ctl.push) begin
            n_top = r_top + rkt_pkg::TOP_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= rkt_pkg::TOP_BITS'(rkt_pkg::SLOTS);
            r_ent_vld <= '0;
        end else begin
            r_top <= n_top;
            if (i_ctl.push) begin
                r_ent_vld[wr_ptr[rkt_pkg::SLOT_BITS-1:0]] <= 1'b1;
            end
        end
    end

    // Stack storage, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            m_stack[wr_ptr[rkt_pkg::SLOT_BITS-1:0]] <= i_ctl.push_slot;
        end
        if (i_ctl.rd) begin
            r_rd_data <= m_stack[rd_ptr[rkt_pkg::SLOT_BITS-1:0]];
            r_rd_vld  <= r_ent_vld[rd_ptr[rkt_pkg::SLOT_BITS-1:0]];
            r_rd_addr <= rd_ptr[rkt_pkg::SLOT_BITS-1:0];
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_sts.full)
        else $error("push onto a full free stack");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_sts.empty)
        else $error("pop from an empty free stack");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |=> r_top == $past(r_top) - rkt_pkg::TOP_BITS'(1))
        else $error("free stack top did not drop on pop");
`endif

endmodule

/* rtl/refcounted_key_table.sv */
// Add: one key compared per cycle until a match; on a hit the count is updated, on a miss
// a slot is allocated from the free stack or full or absent is reported; result registered.
// Remove: count read at acceptance, then update, then result register; an empty slot skips the update.
// One request at a time: ready returns as the result is loaded into the output register;
// a result held by the receiver stalls the next request.
// Reset (synchronous) clears valid bits, free-stack top and control; no clearing pass.
module refcounted_key_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rkt_req_if.sink   i_req,
    rkt_rsp_if.source o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic                           r_op;
    logic [rkt_pkg::KEY_BITS-1:0]   r_key;
    logic [rkt_pkg::COUNT_BITS-1:0] r_delta;
    logic [rkt_pkg::SLOT_BITS-1:0]  r_slot;
    logic [rkt_pkg::SLOT_BITS:0]    r_idx;
    logic                           r_cmp_vld;
    logic [rkt_pkg::SLOT_BITS-1:0]  r_cmp_idx;
    logic [rkt_pkg::KEY_BITS-1:0]   r_key_rd;
    logic [rkt_pkg::COUNT_BITS-1:0] r_cnt_rd;
    logic [rkt_pkg::SLOTS-1:0]      r_valid;
    rkt_pkg::t_rsp                  r_res;
    rkt_pkg::t_rsp                  r_out;
    logic                           r_out_vld;

    logic [rkt_pkg::KEY_BITS-1:0]   m_key [rkt_pkg::SLOTS];
    logic [rkt_pkg::COUNT_BITS-1:0] m_cnt [rkt_pkg::SLOTS];

    rkt_pkg::t_stk_ctl              stk_ctl;
    rkt_pkg::t_stk_sts              stk_sts;
    logic [rkt_pkg::SLOT_BITS-1:0]  stk_slot;

    logic                           req_acc;
    logic                           out_free;
    logic                           hit;
    logic                           scan_end;
    logic                           issue;
    logic [rkt_pkg::SLOT_BITS-1:0]  cnt_ra;
    logic [rkt_pkg::SLOT_BITS-1:0]  cnt_wa;
    logic                           cnt_we;
    logic                           key_we;
    logic                           alu_sub;
    logic [rkt_pkg::COUNT_BITS-1:0] alu_a;
    logic [rkt_pkg::COUNT_BITS-1:0] alu_b;
    logic [rkt_pkg::COUNT_BITS:0]   alu_sum;
    logic [rkt_pkg::COUNT_BITS-1:0] alu_res;
    logic                           rel;

    assign req_acc     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_vld || o_rsp.ready;

    // Scan compare on the registered key read
    assign issue    = (r_state == S_SCAN) && !r_idx[rkt_pkg::SLOT_BITS];
    assign hit      = (r_state == S_SCAN) && r_cmp_vld && r_valid[r_cmp_idx] &&
                      (r_key_rd == r_key);
    assign scan_end = (r_state == S_SCAN) && r_cmp_vld && !hit &&
                      (r_cmp_idx == rkt_pkg::SLOT_BITS'(rkt_pkg::SLOTS - 1));

    // Shared saturating add / clamping subtract
    assign alu_sub = (r_state == S_UPD) && (r_op == rkt_pkg::OP_REMOVE);
    assign alu_a   = (r_state == S_POP) ? '0 : r_cnt_rd;
    assign alu_b   = alu_sub ? ~r_delta : r_delta;
    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} +
                     {{rkt_pkg::COUNT_BITS{1'b0}}, alu_sub};
    always_comb begin
        if (alu_sub) begin
            alu_res = alu_sum[rkt_pkg::COUNT_BITS] ?
                      alu_sum[rkt_pkg::COUNT_BITS-1:0] : '0;
        end else begin
            alu_res = alu_sum[rkt_pkg::COUNT_BITS] ?
                      rkt_pkg::COUNT_MAX : alu_sum[rkt_pkg::COUNT_BITS-1:0];
        end
    end

    assign rel = alu_sub && (alu_res == '0);

    // Memory addressing
    assign cnt_ra = (r_state == S_IDLE) ? i_req.slot_in : r_cmp_idx;
    assign cnt_we = (r_state == S_UPD) || (r_state == S_POP);
    assign cnt_wa = (r_state == S_POP) ? stk_slot : r_slot;
    assign key_we = (r_state == S_POP);

    // Free stack control
    assign stk_ctl.rd        = scan_end && (r_delta != '0) && !stk_sts.empty;
    assign stk_ctl.pop       = (r_state == S_POP);
    assign stk_ctl.push      = (r_state == S_UPD) && rel && !stk_sts.full;
    assign stk_ctl.push_slot = r_slot;

    rkt_free_stack u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_sts   (stk_sts),
        .o_slot  (stk_slot)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.op == rkt_pkg::OP_ADD) begin
                        n_state = S_SCAN;
                    end else if (r_valid[i_req.slot_in]) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = S_UPD;
                end else if (scan_end) begin
                    n_state = stk_ctl.rd ? S_POP : S_RESP;
                end
            end
            S_UPD:  n_state = S_RESP;
            S_POP:  n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= issue;
            if (r_state == S_POP) begin
                r_valid[stk_slot] <= 1'b1;
            end else if ((r_state == S_UPD) && rel) begin
                r_valid[r_slot] <= 1'b0;
            end
            if ((r_state == S_RESP) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Request capture, scan index and pending response
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_op    <= i_req.op;
            r_key   <= i_req.key;
            r_delta <= i_req.ref_delta;
            r_slot  <= i_req.slot_in;
            r_idx   <= '0;
            r_res   <= '{status: rkt_pkg::ST_ABSENT, slot_out: i_req.slot_in,
                         ref_total: '0, released: 1'b0};
        end
        if (issue) begin
            r_idx     <= r_idx + (rkt_pkg::SLOT_BITS + 1)'(1);
            r_cmp_idx <= r_idx[rkt_pkg::SLOT_BITS-1:0];
        end
        if (hit) begin
            r_slot <= r_cmp_idx;
        end
        if (scan_end) begin
            r_res <= '{status: (r_delta == '0) ? rkt_pkg::ST_ABSENT : rkt_pkg::ST_FULL,
                       slot_out: '0, ref_total: '0, released: 1'b0};
        end
        if (r_state == S_UPD) begin
            r_res <= '{status: rkt_pkg::ST_OK, slot_out: r_slot,
                       ref_total: alu_res, released: rel};
        end
        if (r_state == S_POP) begin
            r_res <= '{status: rkt_pkg::ST_OK, slot_out: stk_slot,
                       ref_total: alu_res, released: 1'b0};
        end
        if ((r_state == S_RESP) && out_free) begin
            r_out <= r_res;
        end
    end

    // Key and count stores, registered reads
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            m_key[stk_slot] <= r_key;
        end
        if (issue) begin
            r_key_rd <= m_key[r_idx[rkt_pkg::SLOT_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_wa] <= alu_res;
        end
        r_cnt_rd <= m_cnt[cnt_ra];
    end

    // Response port
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.slot_out  = r_out.slot_out;
    assign o_rsp.ref_total = r_out.ref_total;
    assign o_rsp.released  = r_out.released;

`ifndef ASSERT_OFF
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req.ready)
        else $error("request taken while a transaction is in progress");

    a_upd_valid_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> r_valid[r_slot])
        else $error("count update on a slot not in use");

    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.released) |->
        (o_rsp.status == rkt_pkg::ST_OK) && (o_rsp.ref_total == '0))
        else $error("release reported with nonzero count or bad status");

    a_alloc_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_valid[stk_slot])
        else $error("allocated slot already in use");
`endif

endmodule
